// File: design/assert_macros.svh
// Assertion macros shared by the ordered set design.
// The clock and reset are taken from the names clock and reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define OSIC_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that, when true, implies another one at the next clock edge.
`define OSIC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/osic_pkg.sv
// Package for the ordered set with inversion count: request and response types,
// codes and constants. Depends on nothing.
`timescale 1ns / 1ps

package osic_pkg;

   // Default number of cells in the chain.
   localparam int CAPACITY_DEF = 64;

   // Value returned as the bound when no stored value is greater.
   localparam logic [31:0] NONE_MARK = 32'hFFFF_FFFF;

   // Largest greater count the response field can show.
   localparam logic [6:0] COUNT_MAX = 7'd127;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_SEARCH = 2'd2,
      ACT_UPPER  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_FULL      = 2'd2,
      ST_ABSENT    = 2'd3
   } status_type;

   typedef enum logic {
      FSM_IDLE   = 1'b0,
      FSM_FINISH = 1'b1
   } state_type;

   typedef struct packed {
      action_type         action;
      logic signed [31:0] value;
      logic               first;
   } req_type;

   typedef struct packed {
      logic               found;
      logic signed [31:0] bound_value;
      logic [6:0]         greater_count;
      logic [31:0]        total;
      status_type         status;
   } rsp_type;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic               cmp;
      logic               ins;
      logic               del;
      logic signed [31:0] value;
   } cell_cmd_type;

endpackage

// File: design/osic_cell.sv
// One cell of the sorted chain: holds one value and its compare flags.
// Depends on osic_pkg for the command type.
`timescale 1ns / 1ps

module osic_cell (
   input  logic                      clock,
   input  osic_pkg::cell_cmd_type    cmd,
   input  logic                      occupied,
   input  logic                      left_lt,
   input  logic signed [31:0]        left_val,
   input  logic signed [31:0]        right_val,
   output logic signed [31:0]        val,
   output logic                      lt,
   output logic                      gt,
   output logic                      eq
);

   logic signed [31:0] val_ff;
   logic signed [31:0] val_in;
   logic               lt_ff;
   logic               gt_ff;
   logic               eq_ff;

   // Compare the held value against the broadcast operand; only stored entries count.
   always_ff @(posedge clock) begin
      if (cmd.cmp) begin
         lt_ff <= occupied && (val_ff < cmd.value);
         gt_ff <= occupied && (val_ff > cmd.value);
         eq_ff <= occupied && (val_ff == cmd.value);
      end
   end

   // Cells at or above the insert or delete position shift by one place.
   always_comb begin
      val_in = val_ff;
      if (cmd.ins && !lt_ff) begin
         if (left_lt) begin
            val_in = cmd.value;
         end else begin
            val_in = left_val;
         end
      end else if (cmd.del && !lt_ff) begin
         val_in = right_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;
   assign lt  = lt_ff;
   assign gt  = gt_ff;
   assign eq  = eq_ff;

endmodule

// File: design/ordered_set_inversion_counter.sv
// A request is taken in the idle state, where the cells register their compare flags; in the
// finish state the priority encode, count and shift of the chain happen, and the response is
// registered once the response register has room. No new request is taken until then.
// The response register frees the input side while a response waits to be taken.
// Reset clears the occupancy count and the running total at once; no clearing pass.
`timescale 1ns / 1ps

module ordered_set_inversion_counter #(
   parameter int CAPACITY = osic_pkg::CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  osic_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output osic_pkg::rsp_type rsp_data
);

   `include "assert_macros.svh"

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   osic_pkg::state_type    state_ff;
   osic_pkg::state_type    state_in;
   logic [CNT_W-1:0]       occ_ff;
   logic [CNT_W-1:0]       occ_in;
   logic [31:0]            total_ff;
   logic [31:0]            total_in;
   osic_pkg::req_type      hold_ff;
   logic                   rsp_valid_ff;
   osic_pkg::rsp_type      rsp_data_ff;
   osic_pkg::rsp_type      rsp_data_in;

   logic                   req_fire;
   logic                   finish_fire;
   osic_pkg::cell_cmd_type cmd;

   logic signed [31:0]     cell_val [CAPACITY];
   logic [CAPACITY-1:0]    cell_lt;
   logic [CAPACITY-1:0]    cell_gt;
   logic [CAPACITY-1:0]    cell_eq;
   logic [CAPACITY-1:0]    occupied;
   logic [CAPACITY-1:0]    first_gt;

   logic                   present;
   logic                   any_gt;
   logic [IDX_W-1:0]       gt_idx;
   logic signed [31:0]     bound_sel;
   logic [CNT_W-1:0]       up_pos;
   logic [CNT_W-1:0]       greater;
   logic [31:0]            greater32;
   logic [31:0]            total_base;
   logic [32:0]            total_sum;
   logic                   do_ins;
   logic                   do_del;

   // Control: idle waits for a request, finish waits for room in the response register.
   always_comb begin
      state_in    = state_ff;
      req_stall   = (state_ff != osic_pkg::FSM_IDLE);
      req_fire    = 1'b0;
      finish_fire = 1'b0;
      case (state_ff)
         osic_pkg::FSM_IDLE: begin
            req_fire = req_valid;
            if (req_valid) begin
               state_in = osic_pkg::FSM_FINISH;
            end
         end
         osic_pkg::FSM_FINISH: begin
            finish_fire = !rsp_valid_ff || !rsp_stall;
            if (finish_fire) begin
               state_in = osic_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = osic_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= osic_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the request for the finishing cycle.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         hold_ff <= req_data;
      end
   end

   // Command broadcast to the chain.
   always_comb begin
      cmd.cmp   = req_fire;
      cmd.ins   = finish_fire && do_ins;
      cmd.del   = finish_fire && do_del;
      cmd.value = (state_ff == osic_pkg::FSM_IDLE) ? req_data.value : hold_ff.value;
   end

   // The chain of cells, each linked to its two neighbors.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                left_lt;
      logic signed [31:0]  left_val;
      logic signed [31:0]  right_val;

      assign occupied[i] = (CNT_W'(i) < occ_ff);

      if (i == 0) begin : g_head
         assign left_lt     = 1'b1;
         assign left_val    = cmd.value;
         assign first_gt[i] = cell_gt[i];
      end else begin : g_body
         assign left_lt     = cell_lt[i-1];
         assign left_val    = cell_val[i-1];
         assign first_gt[i] = cell_gt[i] && !cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_val = cell_val[i];
      end else begin : g_next
         assign right_val = cell_val[i+1];
      end

      osic_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occupied  (occupied[i]),
         .left_lt   (left_lt),
         .left_val  (left_val),
         .right_val (right_val),
         .val       (cell_val[i]),
         .lt        (cell_lt[i]),
         .gt        (cell_gt[i]),
         .eq        (cell_eq[i])
      );
   end

   // Encode the first greater cell and select its value.
   always_comb begin
      gt_idx    = '0;
      bound_sel = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first_gt[i]) begin
            gt_idx    = gt_idx | IDX_W'(i);
            bound_sel = bound_sel | cell_val[i];
         end
      end
   end

   assign present   = |cell_eq;
   assign any_gt    = |cell_gt;
   assign up_pos    = any_gt ? CNT_W'(gt_idx) : occ_ff;
   assign greater   = occ_ff - up_pos;
   assign greater32 = 32'(greater);

   // Result, set update and running total for the held request.
   always_comb begin
      rsp_data_in.found         = 1'b0;
      rsp_data_in.bound_value   = osic_pkg::NONE_MARK;
      rsp_data_in.greater_count = '0;
      rsp_data_in.status        = osic_pkg::ST_OK;
      do_ins     = 1'b0;
      do_del     = 1'b0;
      occ_in     = occ_ff;
      total_base = total_ff;
      total_sum  = {1'b0, total_ff};
      total_in   = total_ff;
      case (hold_ff.action)
         osic_pkg::ACT_INSERT: begin
            if (hold_ff.first) begin
               total_base = '0;
            end
            if (present) begin
               rsp_data_in.status = osic_pkg::ST_DUPLICATE;
            end else if (occ_ff == CNT_W'(CAPACITY)) begin
               rsp_data_in.status = osic_pkg::ST_FULL;
            end else begin
               do_ins = 1'b1;
               occ_in = occ_ff + CNT_W'(1);
            end
            total_sum = {1'b0, total_base} + {1'b0, greater32};
            total_in  = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
            rsp_data_in.greater_count = (greater32 > 32'(osic_pkg::COUNT_MAX)) ?
                                        osic_pkg::COUNT_MAX : greater32[6:0];
         end
         osic_pkg::ACT_DELETE: begin
            if (present) begin
               do_del = 1'b1;
               occ_in = occ_ff - CNT_W'(1);
            end else begin
               rsp_data_in.status = osic_pkg::ST_ABSENT;
            end
         end
         osic_pkg::ACT_SEARCH: begin
            rsp_data_in.found = present;
         end
         osic_pkg::ACT_UPPER: begin
            if (any_gt) begin
               rsp_data_in.found       = 1'b1;
               rsp_data_in.bound_value = bound_sel;
            end
         end
         default: begin
            rsp_data_in.status = osic_pkg::ST_OK;
         end
      endcase
      rsp_data_in.total = total_in;
   end

   // Occupancy and total registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff   <= '0;
         total_ff <= '0;
      end else if (finish_fire) begin
         occ_ff   <= occ_in;
         total_ff <= total_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The set never holds more entries than there are cells.
   `OSIC_ASSERT_ALWAYS(a_occ_range, occ_ff <= CNT_W'(CAPACITY), "occupancy above capacity")
   // Stored values are distinct, so at most one cell matches.
   `OSIC_ASSERT_ALWAYS(a_eq_single, (state_ff != osic_pkg::FSM_FINISH) || $onehot0(cell_eq), "several cells match")
   // Greater cells form one run at the top of the set.
   `OSIC_ASSERT_ALWAYS(a_gt_run, (state_ff != osic_pkg::FSM_FINISH) || $onehot0(first_gt), "greater cells not contiguous")
   // A successful insert grows the set by exactly one.
   `OSIC_ASSERT_NEXT(a_ins_grow, finish_fire && do_ins, occ_ff == $past(occ_ff) + CNT_W'(1), "insert did not grow set")

endmodule
